// ----- design/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam int KeyW    = 12;
  localparam int WeightW = 4;
  localparam int EntryW  = KeyW + WeightW;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [EntryW-1:0]  entry_t;

  // Outcome of comparing a stored key against the request key.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

// ----- design/sorted_key_table_unit.sv -----
// Sorted key table: top level with the scan sequencer and result register.
// Busy stays high while an accepted item scans the held entries, and the result strobe
// follows on the next cycle. A new item may start on the strobe cycle; no item is accepted
// while busy. The scan grows with the entry count, as the memory has a single read port.
// Reset (rst_n low, synchronous) empties the table; the entry memory is not cleared.
module sorted_key_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [1:0] in_key_class,
  input  logic [9:0] in_key_number,
  input  logic [3:0] in_weight,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [6:0] out_entry_count,
  output logic [9:0] out_weight_total
);
  import skt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(CAPACITY * 15 + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic          req_r, req_nxt;
  key_t          key_r, key_nxt;
  weight_t       wgt_r, wgt_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] d_idx_r, d_idx_nxt;
  logic          dup_r, dup_nxt;
  logic          placed_r, placed_nxt;
  logic          found_r, found_nxt;
  entry_t        carry_r, carry_nxt;
  weight_t       rmw_r, rmw_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_count_r, out_count_nxt;
  logic [9:0]    out_total_r, out_total_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  cmp_t          cmp;
  logic          full;
  logic          scan_done;
  logic [CW-1:0] new_count;
  logic [TW-1:0] new_total;

  skt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  skt_cmp u_cmp (
    .slot_key (rd_data[KeyW-1:0]),
    .req_key  (key_r),
    .result   (cmp)
  );

  assign full      = (count_r == CW'(CAPACITY));
  assign scan_done = (rd_idx_r == count_r) && !dv_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    wgt_nxt        = wgt_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = 1'b0;
    d_idx_nxt      = rd_idx_r[AW-1:0];
    dup_nxt        = dup_r;
    placed_nxt     = placed_r;
    found_nxt      = found_r;
    carry_nxt      = carry_r;
    rmw_nxt        = rmw_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = d_idx_r;
    wr_data        = rd_data;
    new_count      = count_r;
    new_total      = total_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req_type;
          key_nxt    = {in_key_class, in_key_number};
          wgt_nxt    = in_weight;
          rd_idx_nxt = '0;
          dup_nxt    = 1'b0;
          placed_nxt = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; its data is handled on the following cycle.
        if (rd_idx_r != count_r) begin
          rd_en      = 1'b1;
          dv_nxt     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end

        if (dv_r) begin
          if (req_r == REQ_INSERT) begin
            // Past the insertion point every entry moves up by one slot.
            if (placed_r) begin
              wr_en     = 1'b1;
              wr_data   = carry_r;
              carry_nxt = rd_data;
            end else if (!dup_r) begin
              if (cmp.eq) begin
                dup_nxt = 1'b1;
              end else if (cmp.gt && !full) begin
                wr_en      = 1'b1;
                wr_data    = {wgt_r, key_r};
                carry_nxt  = rd_data;
                placed_nxt = 1'b1;
              end
            end
          end else begin
            // Past the removed entry every entry moves down by one slot.
            if (found_r) begin
              wr_en   = 1'b1;
              wr_addr = d_idx_r - 1'b1;
            end else if (cmp.eq) begin
              found_nxt = 1'b1;
              rmw_nxt   = rd_data[EntryW-1:KeyW];
            end
          end
        end

        if (scan_done) begin
          if (req_r == REQ_INSERT) begin
            if (dup_r) begin
              out_status_nxt = ST_DUPLICATE;
            end else if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = count_r[AW-1:0];
              wr_data        = placed_r ? carry_r : {wgt_r, key_r};
              new_count      = count_r + 1'b1;
              new_total      = total_r + TW'(wgt_r);
              out_status_nxt = ST_INSERTED;
            end
          end else begin
            if (found_r) begin
              new_count      = count_r - 1'b1;
              new_total      = total_r - TW'(rmw_r);
              out_status_nxt = ST_REMOVED;
            end else begin
              out_status_nxt = ST_NOT_FOUND;
            end
          end
          count_nxt     = new_count;
          total_nxt     = new_total;
          out_count_nxt = (32'(new_count) > 32'd127) ? 7'd127 : 7'(new_count);
          out_total_nxt = (32'(new_total) > 32'd1023) ? 10'd1023 : 10'(new_total);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    wgt_r        <= wgt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    d_idx_r      <= d_idx_nxt;
    dup_r        <= dup_nxt;
    placed_r     <= placed_nxt;
    found_r      <= found_nxt;
    carry_r      <= carry_nxt;
    rmw_r        <= rmw_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign busy             = (state_r == S_SCAN);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_weight_total = out_total_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start a scan");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a scan");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> $stable(count_r))
    else $error("table changed on a full rejection");

endmodule

// ----- design/skt_mem.sv -----
// Entry storage: one write port and one registered read port.
module skt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output skt_pkg::entry_t    rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  skt_pkg::entry_t    wr_data
);
  import skt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/skt_cmp.sv -----
// Shared key comparator used once per scanned entry.
module skt_cmp (
  input  skt_pkg::key_t slot_key,
  input  skt_pkg::key_t req_key,
  output skt_pkg::cmp_t result
);
  import skt_pkg::*;

  // The class code sits in the upper bits, so a plain compare orders by class, then number.
  always_comb begin
    result.eq = (slot_key == req_key);
    result.gt = (slot_key > req_key);
  end

endmodule

// ----- bench/sorted_key_table_checker.sv -----
// Checker for the sorted key table: predicts each request's outcome and compares results.
`timescale 1ns / 100ps

module sorted_key_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_req_type,
  input  logic [1:0] in_key_class,
  input  logic [9:0] in_key_number,
  input  logic [3:0] in_weight,
  input  logic       out_valid,
  input  logic [2:0] out_status,
  input  logic [6:0] out_entry_count,
  input  logic [9:0] out_weight_total,
  output int         fail_count,
  output int         pending,
  output int         results_checked,
  output int         n_inserted,
  output int         n_duplicate,
  output int         n_full,
  output int         n_removed,
  output int         n_not_found
);

  import skt_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] count;
    logic [9:0] total;
  } table_outcome_t;

  // Shadow copy of the table, ascending by key, plus its exact count and weight sum.
  entry_t shadow_entries [CAPACITY];
  int     shadow_held;
  int     shadow_sum;

  table_outcome_t outcome_q [$];

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic table_outcome_t apply_request(input logic req, input key_t key,
                                                   input weight_t wgt);
    table_outcome_t r;
    int             pos;
    int             at;
    pos = shadow_held;
    for (int i = 0; i < shadow_held; i++) begin
      if (shadow_entries[i][KeyW-1:0] == key) pos = i;
    end
    if (req == REQ_INSERT) begin
      if (pos < shadow_held) begin
        r.status = ST_DUPLICATE;
      end else if (shadow_held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        at = 0;
        while (at < shadow_held && shadow_entries[at][KeyW-1:0] < key) at++;
        for (int i = shadow_held; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[at] = {wgt, key};
        shadow_held++;
        shadow_sum += int'(wgt);
        r.status = ST_INSERTED;
      end
    end else begin
      if (pos < shadow_held) begin
        shadow_sum -= int'(shadow_entries[pos][EntryW-1:KeyW]);
        for (int i = pos; i + 1 < shadow_held; i++) shadow_entries[i] = shadow_entries[i+1];
        shadow_held--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    // The outputs saturate; inside, the count and the sum are exact.
    r.count = (shadow_held > 127) ? 7'd127 : 7'(shadow_held);
    r.total = (shadow_sum > 1023) ? 10'd1023 : 10'(shadow_sum);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_outcome_t want;
    if (!rst_n) begin
      outcome_q.delete();
      shadow_held = 0;
      shadow_sum = 0;
      fail_count = 0;
      results_checked = 0;
      n_inserted = 0;
      n_duplicate = 0;
      n_full = 0;
      n_removed = 0;
      n_not_found = 0;
    end else begin
      // A result may share its edge with the next accepted item, so compare first.
      if (out_valid) begin
        results_checked++;
        if (outcome_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no request outstanding",
                               results_checked));
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status)
            flag_error($sformatf("result %0d: status %0d, expected %0d",
                                 results_checked, out_status, want.status));
          if (out_entry_count !== want.count)
            flag_error($sformatf("result %0d: entry count %0d, expected %0d",
                                 results_checked, out_entry_count, want.count));
          if (out_weight_total !== want.total)
            flag_error($sformatf("result %0d: weight total %0d, expected %0d",
                                 results_checked, out_weight_total, want.total));
          case (want.status)
            ST_INSERTED:  n_inserted++;
            ST_DUPLICATE: n_duplicate++;
            ST_FULL:      n_full++;
            ST_REMOVED:   n_removed++;
            default:      n_not_found++;
          endcase
        end
      end
      if (start && !busy)
        outcome_q.push_back(apply_request(in_req_type, {in_key_class, in_key_number},
                                          in_weight));
    end
    pending = outcome_q.size();
  end

endmodule

// ----- bench/tb_sorted_key_table_unit.sv -----
// Testbench top for the sorted key table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_key_table_unit;

  import skt_pkg::*;

  localparam int TableCapacity = 64;
  localparam int RandomItems   = 2000;
  localparam int PhaseLength   = 150;
  localparam int CycleLimit    = 1000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_req_type = REQ_INSERT;
  logic [1:0] in_key_class = '0;
  logic [9:0] in_key_number = '0;
  logic [3:0] in_weight = '0;
  logic       out_valid;
  logic [2:0] out_status;
  logic [6:0] out_entry_count;
  logic [9:0] out_weight_total;

  int fail_count;
  int pending;
  int results_checked;
  int n_inserted;
  int n_duplicate;
  int n_full;
  int n_removed;
  int n_not_found;

  int   cycle_count = 0;
  bit   no_gaps = 1'b0;
  key_t recent_keys [$];

  always #5 clk = ~clk;

  sorted_key_table_unit #(.CAPACITY(TableCapacity)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_key_class     (in_key_class),
    .in_key_number    (in_key_number),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_weight_total (out_weight_total)
  );

  sorted_key_table_checker #(.CAPACITY(TableCapacity)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_key_class     (in_key_class),
    .in_key_number    (in_key_number),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_weight_total (out_weight_total),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .n_inserted       (n_inserted),
    .n_duplicate      (n_duplicate),
    .n_full           (n_full),
    .n_removed        (n_removed),
    .n_not_found      (n_not_found)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_request(input logic req, input logic [1:0] cls, input logic [9:0] num,
                              input logic [3:0] wgt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_key_class <= cls;
    in_key_number <= num;
    in_weight <= wgt;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req == REQ_INSERT) begin
      recent_keys.push_back({cls, num});
      if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    end
  endtask

  // Removes mostly target keys seen before; inserts mostly use fresh keys.
  function automatic key_t pick_key(input logic req);
    int reuse_pct;
    reuse_pct = (req == REQ_REMOVE) ? 80 : 25;
    if (recent_keys.size() > 0 && $urandom_range(0, 99) < reuse_pct)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if ($urandom_range(0, 9) == 0)
      return {2'($urandom_range(0, 3)), ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0};
    return {2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023))};
  endfunction

  initial begin : stimulus
    int   insert_pct;
    logic req;
    key_t key;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, both key extremes, ordering across the class boundary,
    // removal at head, middle and tail, and removal of the only entry.
    send_request(REQ_REMOVE, 2'd0, 10'd0,    4'd15);
    send_request(REQ_INSERT, 2'd0, 10'd0,    4'd15);
    send_request(REQ_INSERT, 2'd0, 10'd0,    4'd0);
    send_request(REQ_INSERT, 2'd3, 10'd1023, 4'd15);
    send_request(REQ_INSERT, 2'd1, 10'd512,  4'd7);
    send_request(REQ_INSERT, 2'd0, 10'd1023, 4'd1);
    send_request(REQ_INSERT, 2'd1, 10'd0,    4'd2);
    send_request(REQ_INSERT, 2'd2, 10'd0,    4'd8);
    send_request(REQ_REMOVE, 2'd1, 10'd512,  4'd15);
    send_request(REQ_REMOVE, 2'd0, 10'd0,    4'd0);
    send_request(REQ_REMOVE, 2'd3, 10'd1023, 4'd3);
    send_request(REQ_REMOVE, 2'd3, 10'd1023, 4'd0);
    send_request(REQ_REMOVE, 2'd0, 10'd1023, 4'd0);
    send_request(REQ_REMOVE, 2'd1, 10'd0,    4'd9);
    send_request(REQ_REMOVE, 2'd2, 10'd0,    4'd0);
    send_request(REQ_INSERT, 2'd2, 10'd5,    4'd9);
    send_request(REQ_REMOVE, 2'd2, 10'd5,    4'd6);
    send_request(REQ_INSERT, 2'd3, 10'd1023, 4'd0);
    send_request(REQ_INSERT, 2'd0, 10'd0,    4'd15);

    // Random: phases alternate between filling past capacity, mixed traffic and draining.
    insert_pct = 90;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseLength == 0) begin
        case ((n / PhaseLength) % 3)
          0:       insert_pct = 90;
          1:       insert_pct = 50;
          default: insert_pct = 10;
        endcase
      end
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      key = pick_key(req);
      send_request(req, key[11:10], key[9:0], 4'($urandom_range(0, 15)));
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TableCapacity + 4) @(posedge clk);

    $display("Checked %0d results: %0d inserted, %0d duplicate, %0d full,",
             results_checked, n_inserted, n_duplicate, n_full);
    $display("%0d removed, %0d not found", n_removed, n_not_found);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
